// ===== src/hee_pkg.sv =====
// Shared types, character codes and entity lookup functions for the HTML entity escaper.
// No dependencies.
package hee_pkg;

    localparam int unsigned LEN_W = 3;

    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_QUOT  = 8'h22;
    localparam logic [7:0] CHAR_AMP   = 8'h26;
    localparam logic [7:0] CHAR_SEMI  = 8'h3B;
    localparam logic [7:0] CHAR_LT    = 8'h3C;
    localparam logic [7:0] CHAR_GT    = 8'h3E;
    localparam logic [7:0] CHAR_A     = 8'h61;
    localparam logic [7:0] CHAR_G     = 8'h67;
    localparam logic [7:0] CHAR_L     = 8'h6C;
    localparam logic [7:0] CHAR_M     = 8'h6D;
    localparam logic [7:0] CHAR_O     = 8'h6F;
    localparam logic [7:0] CHAR_P     = 8'h70;
    localparam logic [7:0] CHAR_Q     = 8'h71;
    localparam logic [7:0] CHAR_T     = 8'h74;
    localparam logic [7:0] CHAR_U     = 8'h75;

    localparam logic [15:0] CAPACITY_RESET = 16'd2048;

    typedef enum logic [2:0] {
        KIND_BYTE = 3'd0,
        KIND_QUOT = 3'd1,
        KIND_AMP  = 3'd2,
        KIND_LT   = 3'd3,
        KIND_GT   = 3'd4
    } kind_t;

    // One accepted item handed from the classifier to the expander.
    typedef struct packed {
        logic             valid;
        kind_t            kind;
        logic [7:0]       raw;
        logic [LEN_W-1:0] len;
    } hee_job_t;

    function automatic kind_t classify_byte(input logic [7:0] b);
        kind_t k;
        case (b)
            CHAR_QUOT: k = KIND_QUOT;
            CHAR_AMP:  k = KIND_AMP;
            CHAR_LT:   k = KIND_LT;
            CHAR_GT:   k = KIND_GT;
            default:   k = KIND_BYTE;
        endcase
        return k;
    endfunction

    function automatic logic [LEN_W-1:0] kind_len(input kind_t k);
        logic [LEN_W-1:0] n;
        case (k)
            KIND_QUOT: n = 3'd6;
            KIND_AMP:  n = 3'd5;
            KIND_LT:   n = 3'd4;
            KIND_GT:   n = 3'd4;
            default:   n = 3'd1;
        endcase
        return n;
    endfunction

    function automatic logic [7:0] entity_char(input kind_t k, input logic [LEN_W-1:0] idx,
                                               input logic [7:0] raw);
        logic [7:0] c;
        c = CHAR_SEMI;
        case (k)
            KIND_QUOT: begin
                case (idx)
                    3'd0:    c = CHAR_AMP;
                    3'd1:    c = CHAR_Q;
                    3'd2:    c = CHAR_U;
                    3'd3:    c = CHAR_O;
                    3'd4:    c = CHAR_T;
                    default: c = CHAR_SEMI;
                endcase
            end
            KIND_AMP: begin
                case (idx)
                    3'd0:    c = CHAR_AMP;
                    3'd1:    c = CHAR_A;
                    3'd2:    c = CHAR_M;
                    3'd3:    c = CHAR_P;
                    default: c = CHAR_SEMI;
                endcase
            end
            KIND_LT: begin
                case (idx)
                    3'd0:    c = CHAR_AMP;
                    3'd1:    c = CHAR_L;
                    3'd2:    c = CHAR_T;
                    default: c = CHAR_SEMI;
                endcase
            end
            KIND_GT: begin
                case (idx)
                    3'd0:    c = CHAR_AMP;
                    3'd1:    c = CHAR_G;
                    3'd2:    c = CHAR_T;
                    default: c = CHAR_SEMI;
                endcase
            end
            default: c = raw;
        endcase
        return c;
    endfunction

endpackage

// ===== src/hee_classify.sv =====
// Classifier for the HTML entity escaper: picks the entity, checks room and tracks position.
// Depends on hee_pkg.
module hee_classify (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    input  logic [7:0]        in_byte,
    input  logic [15:0]       capacity,
    input  logic              take,
    output logic              consume,
    output hee_pkg::hee_job_t job
);

    logic [15:0]                wpos_reg;
    logic [15:0]                wpos_next;
    hee_pkg::kind_t             kind;
    logic [hee_pkg::LEN_W-1:0] len;
    logic [16:0]                need;
    logic                       fits;
    logic                       is_nul;

    assign kind    = hee_pkg::classify_byte(in_byte);
    assign len     = hee_pkg::kind_len(kind);
    assign need    = {1'b0, wpos_reg} + {14'd0, len} + 17'd1;
    assign fits    = need <= {1'b0, capacity};
    assign is_nul  = in_byte == hee_pkg::CHAR_NUL;
    assign consume = in_valid && take;

    always_comb begin
        job.valid = consume && !is_nul && fits;
        job.kind  = kind;
        job.raw   = in_byte;
        job.len   = len;
    end

    always_comb begin
        wpos_next = wpos_reg;
        if (consume) begin
            if (is_nul) begin
                wpos_next = 16'd0;
            end else if (fits) begin
                wpos_next = need[15:0] - 16'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wpos_reg <= 16'd0;
        end else begin
            wpos_reg <= wpos_next;
        end
    end

endmodule

// ===== src/hee_expand.sv =====
// Expander for the HTML entity escaper: steps through an entity and holds the output register.
// Depends on hee_pkg.
module hee_expand (
    input  logic              aclk,
    input  logic              aresetn,
    input  hee_pkg::hee_job_t job,
    output logic              take,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [7:0]        m_out_byte,
    output logic              m_run_last
);

    logic                       active_reg;
    logic                       active_next;
    hee_pkg::kind_t             kind_reg;
    hee_pkg::kind_t             kind_next;
    logic [7:0]                 raw_reg;
    logic [7:0]                 raw_next;
    logic [hee_pkg::LEN_W-1:0] len_reg;
    logic [hee_pkg::LEN_W-1:0] len_next;
    logic [hee_pkg::LEN_W-1:0] idx_reg;
    logic [hee_pkg::LEN_W-1:0] idx_next;
    logic                       valid_reg;
    logic                       valid_next;
    logic [7:0]                 byte_reg;
    logic [7:0]                 byte_next;
    logic                       last_reg;
    logic                       last_next;
    logic                       out_load;
    logic                       at_last;

    assign out_load = !valid_reg || m_ready;
    assign at_last  = idx_reg == (len_reg - 3'd1);
    assign take     = !active_reg || (out_load && at_last);

    always_comb begin
        active_next = active_reg;
        kind_next   = kind_reg;
        raw_next    = raw_reg;
        len_next    = len_reg;
        idx_next    = idx_reg;
        valid_next  = valid_reg;
        byte_next   = byte_reg;
        last_next   = last_reg;
        if (out_load) begin
            valid_next = active_reg;
            byte_next  = hee_pkg::entity_char(kind_reg, idx_reg, raw_reg);
            last_next  = at_last;
        end
        if (take) begin
            active_next = job.valid;
            kind_next   = job.kind;
            raw_next    = job.raw;
            len_next    = job.len;
            idx_next    = '0;
        end else if (out_load) begin
            idx_next = idx_reg + 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            valid_reg  <= 1'b0;
        end else begin
            active_reg <= active_next;
            valid_reg  <= valid_next;
        end
        kind_reg <= kind_next;
        raw_reg  <= raw_next;
        len_reg  <= len_next;
        idx_reg  <= idx_next;
        byte_reg <= byte_next;
        last_reg <= last_next;
    end

    assign m_valid    = valid_reg;
    assign m_out_byte = byte_reg;
    assign m_run_last = last_reg;

endmodule

// ===== src/html_entity_escaper.sv =====
// Top level of the HTML entity escaper: input register, capacity register, classifier, expander.
// Depends on hee_pkg, hee_classify and hee_expand.
//
//  Channel   Ports                               Direction  Word
//  input     s_valid s_ready s_in_byte           in         one text byte
//  result    m_valid m_ready m_out_byte m_run_last out      one escaped byte
//  config    cfg_wr_en cfg_wr_data               in         capacity, written at once
//
// Bytes passed through stream at one word per cycle while the result side accepts every word.
// An entity holds the expander until all of its four to six output bytes are loaded.
// An accepted byte passes the input register, the expander job registers and the output register.
// Reset clears the write position, sets capacity to 2048 and empties all stages.
// A stall on the result side backs up through the expander to s_ready.
module html_entity_escaper (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_in_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_byte,
    output logic        m_run_last,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data
);

    logic              in_valid_reg;
    logic              in_valid_next;
    logic [7:0]        in_byte_reg;
    logic [7:0]        in_byte_next;
    logic [15:0]       capacity_reg;
    logic [15:0]       capacity_next;
    logic              take;
    logic              consume;
    hee_pkg::hee_job_t job;

    assign s_ready = !in_valid_reg || consume;

    always_comb begin
        in_valid_next = in_valid_reg;
        in_byte_next  = in_byte_reg;
        if (s_ready) begin
            in_valid_next = s_valid;
            in_byte_next  = s_in_byte;
        end
        capacity_next = cfg_wr_en ? cfg_wr_data : capacity_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            capacity_reg <= hee_pkg::CAPACITY_RESET;
        end else begin
            in_valid_reg <= in_valid_next;
            capacity_reg <= capacity_next;
        end
        in_byte_reg <= in_byte_next;
    end

    hee_classify u_classify (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (in_valid_reg),
        .in_byte  (in_byte_reg),
        .capacity (capacity_reg),
        .take     (take),
        .consume  (consume),
        .job      (job)
    );

    hee_expand u_expand (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .job        (job),
        .take       (take),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_byte (m_out_byte),
        .m_run_last (m_run_last)
    );

endmodule

// ===== src/hee_checker.sv =====
// Port-level checks for the HTML entity escaper, attached to the top level by a bind.
// Depends on hee_pkg and html_entity_escaper.
module hee_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [7:0]  m_out_byte,
    input logic        m_run_last
);

    // A stalled result word holds its contents.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_byte) && $stable(m_run_last))
        else $error("result word changed while stalled");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid straight after reset");

    // The quote, less-than and greater-than characters never appear raw on the output.
    a_no_raw: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_out_byte == hee_pkg::CHAR_QUOT || m_out_byte == hee_pkg::CHAR_LT ||
                      m_out_byte == hee_pkg::CHAR_GT))
        else $error("unescaped special character on output");

    // An ampersand that opens an entity is followed at once by the entity's first letter.
    a_entity_next: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_out_byte == hee_pkg::CHAR_AMP && !m_run_last |=>
        m_valid && (m_out_byte == hee_pkg::CHAR_Q || m_out_byte == hee_pkg::CHAR_A ||
                    m_out_byte == hee_pkg::CHAR_L || m_out_byte == hee_pkg::CHAR_G))
        else $error("entity body broken after ampersand");

endmodule

bind html_entity_escaper hee_checker u_hee_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_out_byte  (m_out_byte),
    .m_run_last  (m_run_last)
);

// ===== tb/sv/tb.sv =====
// Self-checking testbench for html_entity_escaper: text bytes go in and the escaped
// words that come out are checked against a local escaping predictor.
// Depends on hee_pkg and the html_entity_escaper RTL.
module tb;

    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned LONG_HOLD     = 400;
    localparam int unsigned IDLE_LIMIT    = 3000;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
    } escaped_word_t;

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        s_valid     = 1'b0;
    logic        s_ready;
    logic [7:0]  s_in_byte   = 8'h00;
    logic        m_valid;
    logic        m_ready     = 1'b0;
    logic [7:0]  m_out_byte;
    logic        m_run_last;
    logic        cfg_wr_en   = 1'b0;
    logic [15:0] cfg_wr_data = 16'h0000;

    logic [7:0]    text_q[$];
    escaped_word_t escaped_q[$];

    int unsigned buf_cap  = hee_pkg::CAPACITY_RESET;
    int unsigned fill_pos = 0;

    int unsigned burst_max  = 8;
    int unsigned gap_max    = 3;
    int unsigned burst_left = 0;
    int unsigned gap_left   = 0;
    logic [15:0] ready_mask = 16'hFFFF;
    logic [3:0]  rx_tick    = 4'd0;
    int unsigned hold_asks   = 0;
    int unsigned hold_served = 0;
    int unsigned stall_left  = 0;

    int unsigned bytes_in    = 0;
    int unsigned words_out   = 0;
    int unsigned mismatches  = 0;
    int unsigned idle_cycles = 0;
    int unsigned cap_writes  = 0;

    html_entity_escaper DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_in_byte   (s_in_byte),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_byte  (m_out_byte),
        .m_run_last  (m_run_last),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always #5 aclk = ~aclk;

    // Works out the escaped words for one text byte and moves the write position on.
    function automatic void escape_byte(input logic [7:0] b);
        string         ent;
        int unsigned   n;
        escaped_word_t w;
        if (b == hee_pkg::CHAR_NUL) begin
            fill_pos = 0;
            return;
        end
        if (fill_pos + 1 >= buf_cap) return;
        case (b)
            hee_pkg::CHAR_QUOT: ent = "&quot;";
            hee_pkg::CHAR_AMP:  ent = "&amp;";
            hee_pkg::CHAR_LT:   ent = "&lt;";
            hee_pkg::CHAR_GT:   ent = "&gt;";
            default:            ent = "";
        endcase
        n = (ent.len() == 0) ? 1 : ent.len();
        if (fill_pos + n + 1 > buf_cap) return;
        for (int k = 0; k < n; k++) begin
            w.out_byte = (ent.len() == 0) ? b : ent[k];
            w.run_last = (k == n - 1);
            escaped_q.push_back(w);
        end
        fill_pos = (fill_pos + n) & 32'h0000_FFFF;
    endfunction

    function automatic logic [7:0] pick_text_byte();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 25) begin
            case ($urandom_range(3))
                0:       return hee_pkg::CHAR_QUOT;
                1:       return hee_pkg::CHAR_AMP;
                2:       return hee_pkg::CHAR_LT;
                default: return hee_pkg::CHAR_GT;
            endcase
        end
        if (r < 35) begin
            case ($urandom_range(3))
                0:       return 8'h01;
                1:       return 8'hFF;
                2:       return 8'h7F;
                default: return 8'h80;
            endcase
        end
        return 8'($urandom_range(255, 1));
    endfunction

    // Mostly NUL-terminated strings; a few are cut short or carry a stray NUL.
    task automatic queue_strings(input int unsigned count, input int unsigned max_len);
        int unsigned queued;
        int unsigned len;
        queued = 0;
        while (queued < count) begin
            len = $urandom_range(max_len, 1);
            for (int k = 0; k < len; k++) begin
                if ($urandom_range(99) < 3) text_q.push_back(hee_pkg::CHAR_NUL);
                else text_q.push_back(pick_text_byte());
            end
            if ($urandom_range(99) < 90) begin
                text_q.push_back(hee_pkg::CHAR_NUL);
                queued++;
            end
            queued += len;
        end
    endtask

    task automatic set_capacity(input logic [15:0] cap);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= cap;
        buf_cap = cap;
        cap_writes++;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_pace(input int unsigned bursts, input int unsigned gaps,
                            input logic [15:0] mask);
        burst_max  = bursts;
        gap_max    = gaps;
        ready_mask = mask;
    endtask

    task automatic wait_drained();
        do @(posedge aclk);
        while (text_q.size() != 0 || s_valid || escaped_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Sender: bursts of random length separated by random gaps.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                escape_byte(s_in_byte);
                bytes_in++;
            end
            if (!s_valid || s_ready) begin
                if (gap_left != 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (text_q.size() != 0) begin
                    s_valid   <= 1'b1;
                    s_in_byte <= text_q.pop_front();
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(burst_max, 1);
                        gap_left   = (gap_max == 0) ? 0 : $urandom_range(gap_max);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: stalls follow a rotating mask, with an occasional long hold-off.
    always @(posedge aclk) begin
        rx_tick <= rx_tick + 4'd1;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (stall_left != 0) begin
            m_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (hold_served != hold_asks) begin
            m_ready     <= 1'b0;
            hold_served <= hold_asks;
            stall_left  <= LONG_HOLD;
        end else begin
            m_ready <= ready_mask[rx_tick] | ($urandom_range(99) < 20);
        end
    end

    always @(posedge aclk) begin
        escaped_word_t want;
        if (aresetn && m_valid && m_ready) begin
            words_out++;
            if (escaped_q.size() == 0) begin
                $error("out_byte: expected no word, actual %h", m_out_byte);
                mismatches++;
            end else begin
                want = escaped_q.pop_front();
                if (m_out_byte !== want.out_byte) begin
                    $error("out_byte: expected %h, actual %h", want.out_byte, m_out_byte);
                    mismatches++;
                end
                if (m_run_last !== want.run_last) begin
                    $error("run_last: expected %b, actual %b", want.run_last, m_run_last);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Timed out with %0d words still outstanding.", escaped_q.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset capacity: field extremes, every entity, ordinary bytes and the NUL.
        set_pace(4, 2, 16'hB6DB);
        text_q.push_back(8'h01);
        text_q.push_back(8'hFF);
        text_q.push_back(hee_pkg::CHAR_QUOT);
        text_q.push_back(hee_pkg::CHAR_AMP);
        text_q.push_back(hee_pkg::CHAR_LT);
        text_q.push_back(hee_pkg::CHAR_GT);
        text_q.push_back(8'h41);
        text_q.push_back(8'h7F);
        text_q.push_back(8'h80);
        text_q.push_back(hee_pkg::CHAR_SEMI);
        text_q.push_back(hee_pkg::CHAR_NUL);
        text_q.push_back(hee_pkg::CHAR_NUL);
        wait_drained();

        // A tight buffer: entities that do not fit are dropped and a full buffer ignores bytes.
        set_capacity(16'd7);
        text_q.push_back(8'h61);
        text_q.push_back(8'h62);
        text_q.push_back(hee_pkg::CHAR_QUOT);
        text_q.push_back(hee_pkg::CHAR_AMP);
        text_q.push_back(hee_pkg::CHAR_LT);
        text_q.push_back(8'h78);
        text_q.push_back(hee_pkg::CHAR_NUL);
        text_q.push_back(hee_pkg::CHAR_LT);
        text_q.push_back(hee_pkg::CHAR_LT);
        text_q.push_back(8'h7A);
        text_q.push_back(8'h7A);
        text_q.push_back(8'h7A);
        text_q.push_back(hee_pkg::CHAR_NUL);
        wait_drained();

        set_capacity(16'd1);
        set_pace(16, 0, 16'hFFFF);
        queue_strings(16, 6);
        wait_drained();

        // Largest buffer, with the sender flooding while the receiver holds off.
        set_capacity(16'hFFFF);
        set_pace(64, 0, 16'hFFFF);
        hold_asks++;
        queue_strings(40, 30);
        wait_drained();

        set_capacity(16'd12);
        set_pace(6, 4, 16'h5A5A);
        queue_strings(40, 14);
        wait_drained();

        set_capacity(16'd2);
        set_pace(3, 6, 16'hF0F0);
        queue_strings(20, 4);
        wait_drained();

        set_capacity(16'd6);
        set_pace(10, 1, 16'h8421);
        queue_strings(20, 8);
        wait_drained();

        set_capacity(hee_pkg::CAPACITY_RESET);
        set_pace(5, 3, 16'hEEEE);
        queue_strings(20, 12);
        wait_drained();

        if (escaped_q.size() != 0) begin
            $error("%0d expected words never arrived", escaped_q.size());
            mismatches++;
        end
        $display("Sent %0d text bytes under %0d capacity writes and checked %0d escaped words.",
                 bytes_in, cap_writes, words_out);
        $display("Mismatches found: %0d.", mismatches);
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ===== files.f =====
src/hee_pkg.sv
src/hee_classify.sv
src/hee_expand.sv
src/html_entity_escaper.sv
src/hee_checker.sv
tb/sv/tb.sv
